// ===== design/cus_pkg.sv =====
// Package for the complex unit sign block.
// Holds the fixed datapath widths, the unit constant and the sideband type.
// Used by every module of the block; depends on nothing.
`default_nettype none

package cus_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int MAG_W  = 16;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int QUO_W  = MAG_W + MAG_W - 1;
    localparam int ROOT_W = MAG_W;
    localparam int OUT_W  = 16;

    localparam int LANE_STAGES = QUO_W + ROOT_W;
    localparam int OUT_TDATA_W = 2 * OUT_W;

    localparam logic signed [OUT_W-1:0] Q_ONE = OUT_W'(16384);

    typedef struct packed {
        logic neg_r;
        logic neg_i;
        logic zero;
    } t_side;

endpackage

`default_nettype wire

// ===== design/cus_prep.sv =====
// Front end: magnitudes, joint normalization to 16 bits, squares and their sum.
// Five register stages; uses cus_pkg.
`default_nettype none

module cus_prep #(
    parameter int SAMPLE_WIDTH = cus_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_ce,
    input  wire logic                           i_valid,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_real,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_imag,
    output logic                                o_valid,
    output cus_pkg::t_side                      o_side,
    output logic [cus_pkg::SQ_W-1:0]            o_sq_r,
    output logic [cus_pkg::SQ_W-1:0]            o_sq_i,
    output logic [cus_pkg::SUM_W-1:0]           o_sum
);

    localparam int MAG_W  = cus_pkg::MAG_W;
    localparam int SQ_W   = cus_pkg::SQ_W;
    localparam int SUM_W  = cus_pkg::SUM_W;
    localparam int NORM_W = (SAMPLE_WIDTH > MAG_W) ? SAMPLE_WIDTH : MAG_W;
    localparam int SH_MAX = NORM_W - MAG_W;
    localparam int SH_W   = (SH_MAX > 0) ? $clog2(SH_MAX + 1) : 1;

    logic                    r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;
    cus_pkg::t_side          r1_side, r2_side, r3_side, r4_side, r5_side;
    cus_pkg::t_side          n1_side;

    logic [SAMPLE_WIDTH-1:0] n1_mag_r, n1_mag_i;
    logic [SAMPLE_WIDTH-1:0] r1_mag_r, r1_mag_i;
    logic [NORM_W-1:0]       w_or;
    logic [SH_W-1:0]         n2_shift, r2_shift;
    logic [SAMPLE_WIDTH-1:0] r2_mag_r, r2_mag_i;
    logic [MAG_W-1:0]        n3_a_r, n3_a_i, r3_a_r, r3_a_i;
    logic [SQ_W-1:0]         r4_sq_r, r4_sq_i, r5_sq_r, r5_sq_i;
    logic [SUM_W-1:0]        r5_sum;

    assign n1_mag_r = i_real[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-i_real) : SAMPLE_WIDTH'(i_real);
    assign n1_mag_i = i_imag[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-i_imag) : SAMPLE_WIDTH'(i_imag);

    assign n1_side.neg_r = i_real[SAMPLE_WIDTH-1];
    assign n1_side.neg_i = i_imag[SAMPLE_WIDTH-1];
    assign n1_side.zero  = (i_real == '0) && (i_imag == '0);

    assign w_or = NORM_W'(r1_mag_r | r1_mag_i);

    always_comb begin
        n2_shift = '0;
        for (int j = SH_MAX; j >= 0; j--) begin
            if ((w_or >> (j + MAG_W)) == '0) begin
                n2_shift = SH_W'(j);
            end
        end
    end

    assign n3_a_r = MAG_W'(NORM_W'(r2_mag_r) >> r2_shift);
    assign n3_a_i = MAG_W'(NORM_W'(r2_mag_i) >> r2_shift);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (i_ce) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_side  <= n1_side;
            r1_mag_r <= n1_mag_r;
            r1_mag_i <= n1_mag_i;
            r2_side  <= r1_side;
            r2_shift <= n2_shift;
            r2_mag_r <= r1_mag_r;
            r2_mag_i <= r1_mag_i;
            r3_side  <= r2_side;
            r3_a_r   <= n3_a_r;
            r3_a_i   <= n3_a_i;
            r4_side  <= r3_side;
            r4_sq_r  <= SQ_W'(r3_a_r) * SQ_W'(r3_a_r);
            r4_sq_i  <= SQ_W'(r3_a_i) * SQ_W'(r3_a_i);
            r5_side  <= r4_side;
            r5_sq_r  <= r4_sq_r;
            r5_sq_i  <= r4_sq_i;
            r5_sum   <= SUM_W'(r4_sq_r) + SUM_W'(r4_sq_i);
        end
    end

    assign o_valid = r5_vld;
    assign o_side  = r5_side;
    assign o_sq_r  = r5_sq_r;
    assign o_sq_i  = r5_sq_i;
    assign o_sum   = r5_sum;

endmodule

`default_nettype wire

// ===== design/cus_div.sv =====
// Pipelined restoring divider: floor(num * 2^30 / den), one quotient bit per stage.
// Requires num <= den; uses cus_pkg.
`default_nettype none

module cus_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_ce,
    input  wire logic [cus_pkg::SQ_W-1:0]    i_num,
    input  wire logic [cus_pkg::SUM_W-1:0]   i_den,
    output logic [cus_pkg::QUO_W-1:0]        o_quo
);

    localparam int SUM_W = cus_pkg::SUM_W;
    localparam int QUO_W = cus_pkg::QUO_W;

    logic [SUM_W-1:0] r_rem [QUO_W];
    logic [SUM_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];

    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        logic [SUM_W:0]   n_trial;
        logic [SUM_W-1:0] src_den;
        logic [QUO_W-1:0] src_quo;
        logic             n_bit;
        logic [SUM_W-1:0] n_rem;

        if (g == 0) begin : g_first
            assign n_trial = (SUM_W + 1)'(i_num);
            assign src_den = i_den;
            assign src_quo = '0;
        end else begin : g_next
            assign n_trial = {r_rem[g-1], 1'b0};
            assign src_den = r_den[g-1];
            assign src_quo = r_quo[g-1];
        end

        assign n_bit = n_trial >= {1'b0, src_den};
        assign n_rem = n_bit ? SUM_W'(n_trial - {1'b0, src_den}) : SUM_W'(n_trial);

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[g] <= n_rem;
                r_den[g] <= src_den;
                r_quo[g] <= {src_quo[QUO_W-2:0], n_bit};
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

`default_nettype wire

// ===== design/cus_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, most significant first.
// Uses cus_pkg.
`default_nettype none

module cus_sqrt (
    input  wire logic                         i_clk,
    input  wire logic                         i_ce,
    input  wire logic [cus_pkg::QUO_W-1:0]    i_rad,
    output logic [cus_pkg::ROOT_W-1:0]        o_root
);

    localparam int QUO_W  = cus_pkg::QUO_W;
    localparam int ROOT_W = cus_pkg::ROOT_W;
    localparam int TST_W  = 2 * ROOT_W + 1;

    logic [QUO_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        localparam int B = ROOT_W - 1 - g;

        logic [QUO_W-1:0]  src_rem;
        logic [ROOT_W-1:0] src_root;
        logic [TST_W-1:0]  n_test;
        logic              n_bit;

        if (g == 0) begin : g_first
            assign src_rem  = i_rad;
            assign src_root = '0;
        end else begin : g_next
            assign src_rem  = r_rem[g-1];
            assign src_root = r_root[g-1];
        end

        assign n_test = (TST_W'(src_root) << (B + 1)) + (TST_W'(1) << (2 * B));
        assign n_bit  = TST_W'(src_rem) >= n_test;

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[g]  <= n_bit ? QUO_W'(TST_W'(src_rem) - n_test) : src_rem;
                r_root[g] <= n_bit ? (src_root | (ROOT_W'(1) << B)) : src_root;
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

`default_nettype wire

// ===== design/complex_unit_sign_unit.sv =====
// Pipeline from an input transfer to o_m_tvalid: 5 front-end stages,
// 31 divider stages, 16 square-root stages, 1 output register.
// Throughput: one item per cycle while the skid entry is empty; a two-entry output buffer absorbs one stalled result.
// Reset: synchronous, active low; clears all valid bits and the output buffer.
// Top level of the complex unit sign block; uses cus_pkg, cus_prep, cus_div, cus_sqrt.
`default_nettype none

module complex_unit_sign_unit #(
    parameter  int SAMPLE_WIDTH = cus_pkg::SAMPLE_WIDTH_DEF,
    localparam int IN_TDATA_W   = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]             i_s_tdata,  // in_real, in_imag
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [cus_pkg::OUT_TDATA_W-1:0]        o_m_tdata   // unit_real, unit_imag
);

    localparam int SQ_W    = cus_pkg::SQ_W;
    localparam int SUM_W   = cus_pkg::SUM_W;
    localparam int QUO_W   = cus_pkg::QUO_W;
    localparam int ROOT_W  = cus_pkg::ROOT_W;
    localparam int OUT_W   = cus_pkg::OUT_W;
    localparam int STAGES  = cus_pkg::LANE_STAGES;
    localparam int TDATA_W = cus_pkg::OUT_TDATA_W;

    logic                 w_ce;
    logic                 w_prep_vld;
    cus_pkg::t_side       w_prep_side;
    logic [SQ_W-1:0]      w_sq_r, w_sq_i;
    logic [SUM_W-1:0]     w_sum;
    logic [QUO_W-1:0]     w_quo_r, w_quo_i;
    logic [ROOT_W-1:0]    w_root_r, w_root_i;

    logic                 r_vld  [STAGES];
    cus_pkg::t_side       r_side [STAGES];

    logic [ROOT_W:0]      w_inc_r, w_inc_i;
    logic [OUT_W-1:0]     w_mag_r, w_mag_i;
    logic [OUT_W-1:0]     w_unit_r, w_unit_i;
    logic [TDATA_W-1:0]   n_res;
    logic                 w_push;

    logic                 r_out_vld, r_skid_vld;
    logic [TDATA_W-1:0]   r_out_data, r_skid_data;

    assign w_ce       = !r_skid_vld;
    assign o_s_tready = w_ce;

    cus_prep #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (i_s_tvalid),
        .i_real  (i_s_tdata[SAMPLE_WIDTH-1:0]),
        .i_imag  (i_s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .o_valid (w_prep_vld),
        .o_side  (w_prep_side),
        .o_sq_r  (w_sq_r),
        .o_sq_i  (w_sq_i),
        .o_sum   (w_sum)
    );

    cus_div u_div_r (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_num (w_sq_r),
        .i_den (w_sum),
        .o_quo (w_quo_r)
    );

    cus_div u_div_i (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_num (w_sq_i),
        .i_den (w_sum),
        .o_quo (w_quo_i)
    );

    cus_sqrt u_sqrt_r (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_rad  (w_quo_r),
        .o_root (w_root_r)
    );

    cus_sqrt u_sqrt_i (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_rad  (w_quo_i),
        .o_root (w_root_i)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_ce) begin
            r_vld[0] <= w_prep_vld;
            for (int k = 1; k < STAGES; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_side[0] <= w_prep_side;
            for (int k = 1; k < STAGES; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign w_inc_r = {1'b0, w_root_r} + (ROOT_W + 1)'(1);
    assign w_inc_i = {1'b0, w_root_i} + (ROOT_W + 1)'(1);
    assign w_mag_r = OUT_W'(w_inc_r[ROOT_W:1]);
    assign w_mag_i = OUT_W'(w_inc_i[ROOT_W:1]);

    always_comb begin
        if (r_side[STAGES-1].zero) begin
            w_unit_r = cus_pkg::Q_ONE;
            w_unit_i = '0;
        end else begin
            w_unit_r = r_side[STAGES-1].neg_r ? OUT_W'(-w_mag_r) : w_mag_r;
            w_unit_i = r_side[STAGES-1].neg_i ? OUT_W'(-w_mag_i) : w_mag_i;
        end
    end

    assign n_res  = {w_unit_i, w_unit_r};
    assign w_push = w_ce && r_vld[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_out_vld && !i_m_tready) begin
            if (w_push) begin
                r_skid_vld <= 1'b1;
            end
        end else if (r_skid_vld) begin
            r_out_vld  <= 1'b1;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld <= w_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_vld && !i_m_tready) begin
            if (w_push) begin
                r_skid_data <= n_res;
            end
        end else if (r_skid_vld) begin
            r_out_data <= r_skid_data;
        end else begin
            r_out_data <= n_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== design/cus_checker.sv =====
// Port-level checks for complex_unit_sign_unit, attached by bind.
// Uses cus_pkg.
`default_nettype none

module cus_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           o_s_tready,
    input  wire logic                           o_m_tvalid,
    input  wire logic                           i_m_tready,
    input  wire logic [cus_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int OUT_W = cus_pkg::OUT_W;

    logic signed [OUT_W-1:0] w_re, w_im;

    assign w_re = o_m_tdata[OUT_W-1:0];
    assign w_im = o_m_tdata[2*OUT_W-1:OUT_W];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed or dropped while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("output buffer not empty after reset");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input blocked with no result pending");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> w_re <= cus_pkg::Q_ONE && w_re >= -cus_pkg::Q_ONE
                    && w_im <= cus_pkg::Q_ONE && w_im >= -cus_pkg::Q_ONE)
        else $error("unit phasor component out of range");

    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> w_re != '0 || w_im != '0)
        else $error("unit phasor is zero");

endmodule

bind complex_unit_sign_unit cus_checker u_cus_checker (.*);

`default_nettype wire

// ===== test/complex_unit_sign_unit_tb.sv =====
// Self-checking testbench for complex_unit_sign_unit: streams complex samples in, predicts
// each Q1.14 unit phasor and compares every output transfer in order, with random idling.
// Depends on cus_pkg and the complex_unit_sign_unit RTL; needs no files or arguments.
module complex_unit_sign_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W = cus_pkg::SAMPLE_WIDTH_DEF;
    localparam int IN_W     = ((2 * SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_W    = cus_pkg::OUT_W;
    localparam int MAX_WAIT = 11;
    localparam int DRAIN    = 80;

    typedef struct {
        logic signed [SAMPLE_W-1:0] in_real;
        logic signed [SAMPLE_W-1:0] in_imag;
        logic signed [OUT_W-1:0]    unit_real;
        logic signed [OUT_W-1:0]    unit_imag;
    } t_phasor;

    logic                             i_clk      = 1'b0;
    logic                             i_rst_n    = 1'b0;
    logic                             i_s_tvalid = 1'b0;
    logic                             o_s_tready;
    logic [IN_W-1:0]                  i_s_tdata  = '0;  // in_real, in_imag
    logic                             o_m_tvalid;
    logic                             i_m_tready = 1'b0;
    logic [cus_pkg::OUT_TDATA_W-1:0]  o_m_tdata;        // unit_real, unit_imag

    t_phasor expected_phasors[$];
    int      samples_sent    = 0;
    int      phasors_checked = 0;
    int      mismatch_count  = 0;
    bit      src_idle        = 1'b1;
    bit      snk_idle        = 1'b1;

    complex_unit_sign_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int wait_cycles(bit enabled);
        if (!enabled) return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Largest r in 0..16384 with (2r-1)^2 * sum_sq <= mag^2 * 2^30: nearest, ties away from zero.
    function automatic longint unsigned nearest_q14(longint unsigned mag,
                                                    longint unsigned sum_sq);
        longint unsigned target, lo, hi, mid, odd;
        target = (mag * mag) << 30;
        lo = 0;
        hi = 64'(cus_pkg::Q_ONE);
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            odd = 2 * mid - 1;
            if (odd * odd * sum_sq <= target) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic t_phasor unit_phasor(logic signed [SAMPLE_W-1:0] re,
                                            logic signed [SAMPLE_W-1:0] im);
        t_phasor         p;
        int              sre, sim;
        longint unsigned mr, mi, ss;
        sre = re;
        sim = im;
        mr = (sre < 0) ? longint'(-sre) : longint'(sre);
        mi = (sim < 0) ? longint'(-sim) : longint'(sim);
        p.in_real = re;
        p.in_imag = im;
        // real axis and zero; zero counts as positive
        if (mi == 0) begin
            p.unit_real = (sre < 0) ? -cus_pkg::Q_ONE : cus_pkg::Q_ONE;
            p.unit_imag = '0;
        end else begin
            ss = mr * mr + mi * mi;
            mr = nearest_q14(mr, ss);
            mi = nearest_q14(mi, ss);
            p.unit_real = (sre < 0) ? -OUT_W'(mr) : OUT_W'(mr);
            p.unit_imag = (sim < 0) ? -OUT_W'(mi) : OUT_W'(mi);
        end
        return p;
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] re, input logic [SAMPLE_W-1:0] im);
        int gap;
        gap = wait_cycles(src_idle);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_W'({im, re});
        do @(posedge i_clk); while (!o_s_tready);
        expected_phasors.push_back(unit_phasor(re, im));
        samples_sent++;
    endtask

    task automatic check_special_cases();
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd32767, 16'sd0);
        send_sample(-16'sd32768, 16'sd0);
        send_sample(16'sd1, 16'sd0);
        send_sample(-16'sd1, 16'sd0);
        send_sample(16'sd0, 16'sd32767);
        send_sample(16'sd0, -16'sd32768);
        send_sample(16'sd0, 16'sd1);
        send_sample(16'sd0, -16'sd1);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(-16'sd32768, -16'sd32768);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd1, 16'sd1);
        send_sample(-16'sd1, -16'sd1);
        send_sample(16'sd3, -16'sd4);
        send_sample(-16'sd4, 16'sd3);
        send_sample(16'sd1, -16'sd32768);
        send_sample(-16'sd32768, 16'sd1);
        send_sample(16'sd1, 16'sd2);
        send_sample(-16'sd21846, 16'sd10923);
    endtask

    task automatic run_uniform_samples(input int count);
        for (int n = 0; n < count; n++) begin
            send_sample(SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        end
    endtask

    // small parts land close to rounding ties
    task automatic run_small_magnitudes(input int count);
        int re, im;
        for (int n = 0; n < count; n++) begin
            re = $urandom_range(0, 64) - 32;
            im = $urandom_range(0, 64) - 32;
            if ($urandom_range(0, 3) == 0) re = re * $urandom_range(1, 1000);
            send_sample(SAMPLE_W'(re), SAMPLE_W'(im));
        end
    endtask

    task automatic run_axis_samples(input int count);
        int a, b;
        for (int n = 0; n < count; n++) begin
            a = $urandom_range(0, 1) ? -int'($urandom_range(1, 32768))
                                     : int'($urandom_range(0, 32767));
            b = $urandom_range(1, 32767);
            if ($urandom_range(0, 1)) b = -b;
            case ($urandom_range(0, 3))
                0: send_sample(SAMPLE_W'(a), '0);
                1: send_sample('0, SAMPLE_W'(a));
                2: send_sample(SAMPLE_W'(b), ($urandom_range(0, 1)) ? SAMPLE_W'(b)
                                                                     : SAMPLE_W'(-b));
                default: send_sample(($urandom_range(0, 1)) ? -16'sd32768 : 16'sd32767,
                                     SAMPLE_W'(a));
            endcase
        end
    endtask

    task automatic run_full_rate(input int count);
        src_idle = 1'b0;
        snk_idle = 1'b0;
        run_uniform_samples(count);
        // hold the sink back while the source streams at full rate
        snk_idle = 1'b1;
        run_uniform_samples(count / 2);
        src_idle = 1'b1;
    endtask

    initial begin
        t_phasor want;
        int      stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = wait_cycles(snk_idle);
            if (stall != 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            phasors_checked++;
            if (expected_phasors.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected phasor (%0d, %0d)",
                             $signed(o_m_tdata[OUT_W-1:0]), $signed(o_m_tdata[2*OUT_W-1:OUT_W]));
            end else begin
                want = expected_phasors.pop_front();
                if (o_m_tdata[OUT_W-1:0] !== want.unit_real ||
                    o_m_tdata[2*OUT_W-1:OUT_W] !== want.unit_imag) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("phasor of (%0d, %0d): expected (%0d, %0d), got (%0d, %0d)",
                                 want.in_real, want.in_imag, want.unit_real, want.unit_imag,
                                 $signed(o_m_tdata[OUT_W-1:0]),
                                 $signed(o_m_tdata[2*OUT_W-1:OUT_W]));
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_special_cases();
        run_uniform_samples(200);
        run_small_magnitudes(150);
        run_axis_samples(100);
        run_full_rate(120);
        i_s_tvalid <= 1'b0;
        while (expected_phasors.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        $display("Streamed %0d samples (zero, both axes, extremes, near-ties, full-rate bursts)",
                 samples_sent);
        $display("and compared %0d unit phasors; %0d disagreed.", phasors_checked,
                 mismatch_count);
        if (mismatch_count == 0 && expected_phasors.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("run timed out with %0d phasors outstanding", expected_phasors.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
